### rtl/srg_pkg.sv
package srg_pkg;

    localparam int SEED_W   = 29;
    localparam int SAMPLE_W = 30;
    localparam int IDX_W    = 6;

    localparam logic [SAMPLE_W-1:0] MOD_VAL   = 30'd1000000000;
    localparam logic [SAMPLE_W-1:0] SEED_BASE = 30'd161803398;

    localparam logic [IDX_W-1:0] TABLE_LEN  = 6'd55;
    localparam logic [IDX_W-1:0] FILL_LEN   = 6'd54;
    localparam logic [IDX_W-1:0] LAG_STEP   = 6'd21;
    localparam logic [IDX_W-1:0] TRAIL_INIT = 6'd31;
    localparam logic [IDX_W-1:0] MIX_SPLIT  = 6'd24;
    localparam logic [IDX_W-1:0] MIX_FWD    = 6'd31;
    localparam logic [IDX_W-1:0] MIX_BACK   = 6'd24;
    localparam logic [IDX_W-1:0] IDX_FIRST  = 6'd1;
    localparam logic [1:0]       PASS_LAST  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL_START,
        S_FILL,
        S_MIX_RD,
        S_MIX_WR,
        S_STEP_RD,
        S_STEP_WR
    } t_state;

    typedef struct packed {
        logic load;
        logic reseed;
        logic fill_start;
        logic fill_step;
        logic mix_rd;
        logic mix_wr;
        logic step_rd;
        logic step_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic seed_neg;
        logic fill_last;
        logic mix_last;
        logic out_free;
    } t_dp_status;

    // a - b modulo 10^9 for operands already below 10^9
    function automatic logic [SAMPLE_W-1:0] wrap_sub(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[SAMPLE_W]) begin
            d = d + {1'b0, MOD_VAL};
        end
        return d[SAMPLE_W-1:0];
    endfunction

endpackage

### rtl/srg_ctrl.sv
module srg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  srg_pkg::t_dp_status i_status,
    output srg_pkg::t_dp_cmd    o_cmd
);

    srg_pkg::t_state r_state, n_state;
    logic            r_seeded, n_seeded;
    logic            w_accept;
    logic            w_need_reseed;

    assign o_ready       = (r_state == srg_pkg::S_IDLE) && i_rst_n;
    assign w_accept      = o_ready && i_valid;
    assign w_need_reseed = i_status.seed_neg || !r_seeded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srg_pkg::S_IDLE;
            r_seeded <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_seeded <= n_seeded;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_seeded = r_seeded;
        case (r_state)
            srg_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_reseed ? srg_pkg::S_FILL_START : srg_pkg::S_STEP_RD;
                end
            end
            srg_pkg::S_FILL_START: n_state = srg_pkg::S_FILL;
            srg_pkg::S_FILL: begin
                if (i_status.fill_last) begin
                    n_state = srg_pkg::S_MIX_RD;
                end
            end
            srg_pkg::S_MIX_RD: n_state = srg_pkg::S_MIX_WR;
            srg_pkg::S_MIX_WR: begin
                if (i_status.mix_last) begin
                    n_state  = srg_pkg::S_STEP_RD;
                    n_seeded = 1'b1;
                end else begin
                    n_state = srg_pkg::S_MIX_RD;
                end
            end
            srg_pkg::S_STEP_RD: n_state = srg_pkg::S_STEP_WR;
            srg_pkg::S_STEP_WR: begin
                if (i_status.out_free) begin
                    n_state = srg_pkg::S_IDLE;
                end
            end
            default: n_state = srg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = w_accept;
        o_cmd.reseed     = w_need_reseed;
        case (r_state)
            srg_pkg::S_FILL_START: o_cmd.fill_start = 1'b1;
            srg_pkg::S_FILL:       o_cmd.fill_step  = 1'b1;
            srg_pkg::S_MIX_RD:     o_cmd.mix_rd     = 1'b1;
            srg_pkg::S_MIX_WR:     o_cmd.mix_wr     = 1'b1;
            srg_pkg::S_STEP_RD:    o_cmd.step_rd    = 1'b1;
            srg_pkg::S_STEP_WR:    o_cmd.step_wr    = i_status.out_free;
            default: ;
        endcase
    end

endmodule

### rtl/srg_dp.sv
module srg_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  srg_pkg::t_dp_cmd               i_cmd,
    output srg_pkg::t_dp_status            o_status,
    input  logic [srg_pkg::SEED_W-1:0]     i_seed,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [srg_pkg::SAMPLE_W-1:0]   o_sample,
    output logic [srg_pkg::SEED_W-1:0]     o_seed_out,
    output logic                           o_reseeded
);

    logic [srg_pkg::SAMPLE_W-1:0] r_mem [0:srg_pkg::TABLE_LEN];

    logic [srg_pkg::SEED_W-1:0]   r_seed;
    logic                         r_reseed;
    logic [srg_pkg::IDX_W-1:0]    r_lead, n_lead;
    logic [srg_pkg::IDX_W-1:0]    r_trail, n_trail;
    logic [srg_pkg::IDX_W-1:0]    r_idx;
    logic [srg_pkg::IDX_W-1:0]    r_slot;
    logic [1:0]                   r_pass;
    logic [srg_pkg::SAMPLE_W-1:0] r_prev;
    logic [srg_pkg::SAMPLE_W-1:0] r_carry;
    logic [srg_pkg::SAMPLE_W-1:0] r_rd_a;
    logic [srg_pkg::SAMPLE_W-1:0] r_rd_b;
    logic                         r_out_valid;
    logic [srg_pkg::SAMPLE_W-1:0] r_sample;
    logic [srg_pkg::SEED_W-1:0]   r_seed_out;
    logic                         r_reseed_out;

    logic [srg_pkg::SEED_W-1:0]   w_mag;
    logic [srg_pkg::SAMPLE_W-1:0] w_start;
    logic [srg_pkg::IDX_W:0]      w_slot_sum;
    logic [srg_pkg::IDX_W-1:0]    w_slot_next;
    logic [srg_pkg::IDX_W-1:0]    w_mix_src;
    logic [srg_pkg::IDX_W-1:0]    w_idx_next;
    logic [srg_pkg::SAMPLE_W-1:0] w_diff;
    logic                         w_out_free;
    logic                         w_wr_en;
    logic [srg_pkg::IDX_W-1:0]    w_wr_addr;
    logic [srg_pkg::SAMPLE_W-1:0] w_wr_data;
    logic                         w_rd_en;
    logic [srg_pkg::IDX_W-1:0]    w_rd_addr_a;
    logic [srg_pkg::IDX_W-1:0]    w_rd_addr_b;

    // saturated seed magnitude gives the chain start value
    assign w_mag   = r_seed[srg_pkg::SEED_W-1] ? (~r_seed + 29'd1) : r_seed;
    assign w_start = ({1'b0, w_mag} > srg_pkg::SEED_BASE) ? '0
                   : srg_pkg::SEED_BASE - {1'b0, w_mag};

    assign w_slot_sum  = {1'b0, r_slot} + {1'b0, srg_pkg::LAG_STEP};
    assign w_slot_next = (w_slot_sum >= {1'b0, srg_pkg::TABLE_LEN})
                       ? 6'(w_slot_sum - {1'b0, srg_pkg::TABLE_LEN})
                       : w_slot_sum[srg_pkg::IDX_W-1:0];

    assign w_mix_src  = (r_idx <= srg_pkg::MIX_SPLIT) ? r_idx + srg_pkg::MIX_FWD
                                                      : r_idx - srg_pkg::MIX_BACK;
    assign w_idx_next = (r_idx >= srg_pkg::TABLE_LEN) ? srg_pkg::IDX_FIRST
                                                      : r_idx + 6'd1;

    assign n_lead  = (r_lead  >= srg_pkg::TABLE_LEN) ? srg_pkg::IDX_FIRST : r_lead  + 6'd1;
    assign n_trail = (r_trail >= srg_pkg::TABLE_LEN) ? srg_pkg::IDX_FIRST : r_trail + 6'd1;

    assign w_diff     = srg_pkg::wrap_sub(r_rd_a, r_rd_b);
    assign w_out_free = !r_out_valid || i_ready;

    assign o_status.seed_neg  = i_seed[srg_pkg::SEED_W-1];
    assign o_status.fill_last = (r_idx == srg_pkg::FILL_LEN);
    assign o_status.mix_last  = (r_pass == srg_pkg::PASS_LAST) && (r_idx == srg_pkg::TABLE_LEN);
    assign o_status.out_free  = w_out_free;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_lead;
        w_wr_data = w_diff;
        if (i_cmd.fill_start) begin
            w_wr_en   = 1'b1;
            w_wr_addr = srg_pkg::TABLE_LEN;
            w_wr_data = w_start;
        end else if (i_cmd.fill_step) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_slot;
            w_wr_data = r_carry;
        end else if (i_cmd.mix_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_idx;
        end else if (i_cmd.step_wr) begin
            w_wr_en   = 1'b1;
        end
    end

    assign w_rd_en     = i_cmd.mix_rd || i_cmd.step_rd;
    assign w_rd_addr_a = i_cmd.mix_rd ? r_idx     : n_lead;
    assign w_rd_addr_b = i_cmd.mix_rd ? w_mix_src : n_trail;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= r_mem[w_rd_addr_a];
            r_rd_b <= r_mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead      <= '0;
            r_trail     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mix_wr && o_status.mix_last) begin
                r_lead  <= '0;
                r_trail <= srg_pkg::TRAIL_INIT;
            end else if (i_cmd.step_rd) begin
                r_lead  <= n_lead;
                r_trail <= n_trail;
            end
            if (i_cmd.step_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seed   <= i_seed;
            r_reseed <= i_cmd.reseed;
        end
        if (i_cmd.fill_start) begin
            r_prev  <= w_start;
            r_carry <= 30'd1;
            r_slot  <= srg_pkg::LAG_STEP;
            r_idx   <= srg_pkg::IDX_FIRST;
            r_pass  <= '0;
        end else if (i_cmd.fill_step) begin
            // shift the chain: new carry is previous minus current
            r_prev  <= r_carry;
            r_carry <= srg_pkg::wrap_sub(r_prev, r_carry);
            r_slot  <= w_slot_next;
            r_idx   <= o_status.fill_last ? srg_pkg::IDX_FIRST : r_idx + 6'd1;
        end else if (i_cmd.mix_wr) begin
            r_idx <= w_idx_next;
            if (r_idx == srg_pkg::TABLE_LEN) begin
                r_pass <= r_pass + 2'd1;
            end
        end
        if (i_cmd.step_wr) begin
            r_sample     <= w_diff;
            r_seed_out   <= r_reseed ? 29'd1 : r_seed;
            r_reseed_out <= r_reseed;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_sample   = r_sample;
    assign o_seed_out = r_seed_out;
    assign o_reseeded = r_reseed_out;

endmodule

### rtl/subtractive_random_generator.sv
// A seeded item takes a table read, then a subtract and write-back that waits
// for a free output and registers the result. A new item is taken only after
// that write-back through the single-write, two-read table memory. A reseed
// adds 55 chain writes and 4 x 55 read/write mixing steps. Reset (i_rst_n low,
// synchronous) clears control, lead/trail indices and the seeded flag; the
// table is not cleared, the first item after reset always reseeds.
module subtractive_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [28:0] seed_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [29:0] sample, [58:30] seed_out, rest zero
    output logic        m_tuser    // [0] reseeded
);

    srg_pkg::t_dp_cmd             w_cmd;
    srg_pkg::t_dp_status          w_status;
    logic [srg_pkg::SAMPLE_W-1:0] w_sample;
    logic [srg_pkg::SEED_W-1:0]   w_seed_out;

    srg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    srg_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_seed     (s_tdata[srg_pkg::SEED_W-1:0]),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_sample   (w_sample),
        .o_seed_out (w_seed_out),
        .o_reseeded (m_tuser)
    );

    assign m_tdata = {5'd0, w_seed_out, w_sample};

endmodule

### rtl/srg_checker.sv
module srg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[29:0] < 30'd1000000000))
        else $error("sample out of range");

    a_reseed_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> (m_tdata[58:30] == 29'd1))
        else $error("reseeded beat without seed one");

    // an item without reseed had a non-negative seed
    a_plain_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[58])
        else $error("negative seed passed without reseed");

    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind subtractive_random_generator srg_checker u_srg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
